// ===== rtl/core/hscf_pkg.sv =====
// hscf_pkg: shared types, constants and keyword matcher for the http start capture filter
// no dependencies; used by hscf_front, hscf_queue, hscf_back and the core top level
package hscf_pkg;

  // frame layout
  localparam int unsigned POS_W          = 17;
  localparam int unsigned ETH_TYPE_HI    = 12;
  localparam int unsigned ETH_TYPE_LO    = 13;
  localparam int unsigned IP_START       = 14;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam int unsigned IP_LEN_HI_OFF  = 2;
  localparam int unsigned IP_LEN_LO_OFF  = 3;
  localparam int unsigned IP_PROTO_OFF   = 9;
  localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;
  localparam int unsigned MIN_REGION     = 11;
  localparam int unsigned MIN_END_OFF    = 10;

  // lookahead window and capture limit
  localparam int unsigned WIN_DEPTH     = 9;
  localparam int unsigned FILL_W        = $clog2(WIN_DEPTH + 1);
  localparam int unsigned OFF_W         = 16;
  localparam int unsigned CAPTURE_LIMIT = 65536;
  localparam int unsigned CNT_W         = $clog2(CAPTURE_LIMIT + 1);

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  // keywords, first character in the top bits
  localparam int unsigned GET_LEN  = 3;
  localparam int unsigned POST_LEN = 4;
  localparam int unsigned HTTP_LEN = 8;
  localparam logic [8*GET_LEN-1:0]  KW_GET  = "GET";
  localparam logic [8*POST_LEN-1:0] KW_POST = "POST";
  localparam logic [8*HTTP_LEN-1:0] KW_HTTP = "HTTP/1.1";

  typedef enum logic [1:0] {
    ENT_PUSH,
    ENT_PUSH_END,
    ENT_ABORT
  } ent_kind_t;

  typedef struct packed {
    ent_kind_t  kind;
    logic [7:0] data;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0]       data;
    logic [OFF_W-1:0] offset;
    logic             last;
  } cap_t;

  // keyword starting at the oldest window byte, with one more byte behind it
  function automatic logic kw_match(win_t w, logic [FILL_W-1:0] fill);
    logic get_hit;
    logic post_hit;
    logic http_hit;
    get_hit  = (fill >= FILL_W'(GET_LEN + 1)) && ({w[0], w[1], w[2]} == KW_GET);
    post_hit = (fill >= FILL_W'(POST_LEN + 1)) && ({w[0], w[1], w[2], w[3]} == KW_POST);
    http_hit = (fill >= FILL_W'(HTTP_LEN + 1)) &&
               ({w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7]} == KW_HTTP);
    return get_hit || post_hit || http_hit;
  endfunction

endpackage

// ===== rtl/core/hscf_front.sv =====
// hscf_front: frame parser; checks ethertype, ip length and protocol, marks ip region bytes
// depends on hscf_pkg; feeds hscf_queue
module hscf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_ready,
  output hscf_pkg::q_port_t push
);

  localparam int unsigned PW = hscf_pkg::POS_W;

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    eth_high_r, eth_high_nxt;
  logic          accepted_r, accepted_nxt;
  logic [15:0]   tot_r, tot_nxt;

  logic          accept;
  logic [7:0]    b;
  logic          eth_ok;
  logic          acc1;
  logic          in_reg;
  logic [15:0]   tot_cur;
  logic          bad;
  logic          region_end;
  logic          short_region;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;
  assign b         = in_tdata;

  always_comb begin
    eth_ok = (eth_high_r == hscf_pkg::ETHERTYPE_IPV4[15:8]) &&
             (b == hscf_pkg::ETHERTYPE_IPV4[7:0]);
    acc1   = accepted_r && !((pos_r == PW'(hscf_pkg::ETH_TYPE_LO)) && !eth_ok);
    in_reg = acc1 && (pos_r >= PW'(hscf_pkg::IP_START));
    tot_cur = (pos_r == PW'(hscf_pkg::IP_START + hscf_pkg::IP_LEN_LO_OFF)) ?
              {tot_r[15:8], b} : tot_r;
    bad = in_reg &&
          (((pos_r == PW'(hscf_pkg::IP_START + hscf_pkg::IP_LEN_LO_OFF)) &&
            (tot_cur < 16'(hscf_pkg::MIN_REGION))) ||
           ((pos_r == PW'(hscf_pkg::IP_START + hscf_pkg::IP_PROTO_OFF)) &&
            (b != hscf_pkg::IP_PROTO_TCP)));
    // region ends at end of frame or at the last byte covered by the ip total length
    region_end = in_tlast ||
                 ((pos_r >= PW'(hscf_pkg::IP_START + hscf_pkg::IP_LEN_LO_OFF)) &&
                  (pos_r >= ({1'b0, tot_cur} + PW'(hscf_pkg::IP_START - 1))));
    short_region = region_end && (pos_r < PW'(hscf_pkg::IP_START + hscf_pkg::MIN_END_OFF));

    push.valid      = accept && in_reg;
    push.entry.data = b;
    if (bad || short_region) begin
      push.entry.kind = hscf_pkg::ENT_ABORT;
    end else if (region_end) begin
      push.entry.kind = hscf_pkg::ENT_PUSH_END;
    end else begin
      push.entry.kind = hscf_pkg::ENT_PUSH;
    end

    pos_nxt      = pos_r;
    eth_high_nxt = eth_high_r;
    accepted_nxt = accepted_r;
    tot_nxt      = tot_r;
    if (accept) begin
      if (pos_r != {PW{1'b1}}) begin
        pos_nxt = pos_r + PW'(1);
      end
      if (pos_r == PW'(hscf_pkg::ETH_TYPE_HI)) begin
        eth_high_nxt = b;
      end
      if (in_reg && (pos_r == PW'(hscf_pkg::IP_START + hscf_pkg::IP_LEN_HI_OFF))) begin
        tot_nxt = {b, 8'h00};
      end
      if (in_reg && (pos_r == PW'(hscf_pkg::IP_START + hscf_pkg::IP_LEN_LO_OFF))) begin
        tot_nxt = tot_cur;
      end
      accepted_nxt = acc1 && !(in_reg && (bad || region_end));
      if (in_tlast) begin
        pos_nxt      = '0;
        eth_high_nxt = '0;
        accepted_nxt = 1'b1;
        tot_nxt      = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      eth_high_r <= '0;
      accepted_r <= 1'b1;
      tot_r      <= '0;
    end else begin
      pos_r      <= pos_nxt;
      eth_high_r <= eth_high_nxt;
      accepted_r <= accepted_nxt;
      tot_r      <= tot_nxt;
    end
  end

endmodule

// ===== rtl/core/hscf_queue.sv =====
// hscf_queue: short fifo of region byte entries between front and back
// depends on hscf_pkg
module hscf_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  hscf_pkg::q_port_t push,
  output logic              q_ready,
  output hscf_pkg::q_port_t head,
  input  logic              pop
);

  localparam int unsigned PW = hscf_pkg::Q_PTR_W;

  hscf_pkg::q_entry_t entries_r [hscf_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign q_ready    = (cnt_r != (PW + 1)'(hscf_pkg::Q_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = entries_r[rd_ptr_r];
  assign do_push    = push.valid && q_ready;
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (PW + 1)'(1);
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - (PW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/hscf_back.sv =====
// hscf_back: lookahead window, keyword decision, region-end flush and output register
// depends on hscf_pkg; drains hscf_queue
module hscf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  hscf_pkg::q_port_t head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output hscf_pkg::cap_t    out_cap
);

  localparam int unsigned FW = hscf_pkg::FILL_W;
  localparam int unsigned CW = hscf_pkg::CNT_W;
  localparam int unsigned OW = hscf_pkg::OFF_W;
  localparam int unsigned WD = hscf_pkg::WIN_DEPTH;

  hscf_pkg::win_t win_r, win_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic           armed_r, armed_nxt;
  logic           flushing_r, flushing_nxt;
  logic           found_r, found_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [OW-1:0]  off_r, off_nxt;
  logic           out_valid_r, out_valid_nxt;
  hscf_pkg::cap_t cap_r, cap_nxt;

  logic           can_out;
  hscf_pkg::win_t wp;
  hscf_pkg::win_t dec_win;
  logic [FW-1:0]  dec_fill;
  logic           dec;
  logic           found;
  logic           emit;
  logic [CW-1:0]  cnt_inc;
  logic           clear;

  assign out_tvalid = out_valid_r;
  assign out_cap    = cap_r;
  assign can_out    = !out_valid_r || out_tready;
  assign cnt_inc    = cnt_r + CW'(1);

  always_comb begin
    // window with the head byte placed behind the current fill
    wp = win_r;
    for (int i = 0; i < WD; i++) begin
      if (fill_r == FW'(i)) begin
        wp[i] = head.entry.data;
      end
    end

    win_nxt       = win_r;
    fill_nxt      = fill_r;
    armed_nxt     = armed_r;
    flushing_nxt  = flushing_r;
    found_nxt     = found_r;
    cnt_nxt       = cnt_r;
    off_nxt       = off_r;
    out_valid_nxt = out_valid_r;
    cap_nxt       = cap_r;
    pop           = 1'b0;
    dec           = 1'b0;
    dec_win       = win_r;
    dec_fill      = fill_r;
    clear         = 1'b0;
    found         = found_r;
    emit          = 1'b0;

    if (can_out) begin
      if (flushing_r) begin
        dec = 1'b1;
      end else if (head.valid) begin
        case (head.entry.kind)
          hscf_pkg::ENT_ABORT: begin
            pop   = 1'b1;
            clear = 1'b1;
          end
          hscf_pkg::ENT_PUSH, hscf_pkg::ENT_PUSH_END: begin
            if (fill_r == FW'(WD)) begin
              // protocol byte with the window full: decide the oldest before pushing
              dec       = 1'b1;
              armed_nxt = 1'b1;
            end else begin
              pop = 1'b1;
              if (head.entry.kind == hscf_pkg::ENT_PUSH_END) begin
                win_nxt      = wp;
                fill_nxt     = fill_r + FW'(1);
                flushing_nxt = 1'b1;
              end else if (armed_r && (fill_r == FW'(WD - 1))) begin
                dec      = 1'b1;
                dec_win  = wp;
                dec_fill = FW'(WD);
              end else begin
                win_nxt  = wp;
                fill_nxt = fill_r + FW'(1);
              end
            end
          end
          default: begin
            pop = 1'b1;
          end
        endcase
      end

      if (dec) begin
        found = found_r || hscf_pkg::kw_match(dec_win, dec_fill);
        emit  = found && (cnt_r < CW'(hscf_pkg::CAPTURE_LIMIT));
        for (int i = 0; i < WD - 1; i++) begin
          win_nxt[i] = dec_win[i + 1];
        end
        win_nxt[WD - 1] = '0;
        fill_nxt  = dec_fill - FW'(1);
        off_nxt   = off_r + OW'(1);
        found_nxt = found;
        if (emit) begin
          cnt_nxt = cnt_inc;
        end
        if (flushing_r && (dec_fill == FW'(1))) begin
          clear = 1'b1;
        end
      end

      if (clear) begin
        fill_nxt     = '0;
        armed_nxt    = 1'b0;
        flushing_nxt = 1'b0;
        found_nxt    = 1'b0;
        cnt_nxt      = '0;
        off_nxt      = '0;
      end

      out_valid_nxt = emit;
      if (emit) begin
        cap_nxt.data   = dec_win[0];
        cap_nxt.offset = off_r;
        // final emitted byte of the flush: no more entries, or the limit stops the rest
        cap_nxt.last   = flushing_r &&
                         ((dec_fill == FW'(1)) || (cnt_inc >= CW'(hscf_pkg::CAPTURE_LIMIT)));
      end
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    cap_r <= cap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      armed_r     <= 1'b0;
      flushing_r  <= 1'b0;
      found_r     <= 1'b0;
      cnt_r       <= '0;
      off_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      armed_r     <= armed_nxt;
      flushing_r  <= flushing_nxt;
      found_r     <= found_nxt;
      cnt_r       <= cnt_nxt;
      off_r       <= off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/http_start_capture_filter_core.sv =====
// http_start_capture_filter_core: top level of the http start capture filter
// depends on hscf_pkg, hscf_front, hscf_queue and hscf_back
//
//   channel | dir | ports                              | contents
//   --------+-----+------------------------------------+---------------------------------
//   in      | in  | in_tvalid/tready/tdata[7:0]/tlast  | frame byte, tlast = end of frame
//   out     | out | out_tvalid/tready/tdata[23:0]/tlast| captured byte, ip offset, tlast =
//           |     |                                    | final captured byte of the frame
//
// one frame byte per cycle is taken while the 4-entry queue has room; the front parses
// in the same cycle it accepts. the back retires one queue entry or one window decision
// per cycle and one result per cycle unless out_tready holds it: a frame adds a decision at
// the protocol byte and a window flush at the region end, hidden behind the next header.
// reset (rst_n low, synchronous) empties queue, window and output register.
// out_tready low holds the output register and stalls the back; the front keeps taking
// bytes until the queue fills, then drops in_tready.
module http_start_capture_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] frame_byte
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] captured_byte, [23:8] ip_offset
  output logic        out_tlast
);

  hscf_pkg::q_port_t push;
  hscf_pkg::q_port_t head;
  hscf_pkg::cap_t    cap;
  logic              q_ready;
  logic              pop;

  // front: header checks and region marking
  hscf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .push      (push)
  );

  // queue of region bytes and abort marks
  hscf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .head    (head),
    .pop     (pop)
  );

  // back: keyword window, capture decisions and output register
  hscf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_cap    (cap)
  );

  assign out_tdata = {cap.offset, cap.data};
  assign out_tlast = cap.last;

endmodule

// ===== bench/tb_http_start_capture_filter_core.sv =====
// tb_http_start_capture_filter_core: self-checking bench for the http start capture filter
// depends on hscf_pkg and http_start_capture_filter_core; holds its own byte-level predictor
module tb_http_start_capture_filter_core;
  import hscf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // keyword texts, last character in the low bits
  localparam logic [63:0] TXT_GET    = "GET";
  localparam logic [63:0] TXT_POST   = "POST";
  localparam logic [63:0] TXT_HTTP   = "HTTP/1.1";
  localparam logic [63:0] TXT_POS    = "POS";
  localparam logic [63:0] TXT_HTTP10 = "HTTP/1.0";
  localparam logic [63:0] TXT_GE     = "GE";

  localparam logic [16:0] POS_MAX        = 17'h1FFFF;
  localparam int          STUCK_LIMIT    = 3000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          TAIL_CYCLES    = 40;
  localparam int          RANDOM_BYTES   = 360;
  localparam int          MAX_REPORTS    = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] frame_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [7:0] captured_byte, [23:8] ip_offset
  logic        out_tlast;

  http_start_capture_filter_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predictor state: one frame's worth of parsing context
  // -------------------------------------------------------------------------
  logic [16:0] byte_index;
  logic [7:0]  type_high;
  bit          keep_frame;
  logic [15:0] ip_length;
  logic [7:0]  win [WIN_DEPTH];
  logic [3:0]  win_fill;
  bit          http_seen;
  logic [16:0] emitted;

  // captures produced by the current frame byte
  logic [7:0]  step_bytes   [WIN_DEPTH];
  logic [15:0] step_offsets [WIN_DEPTH];
  int          step_count;

  cap_t captures_due [$];
  int   errors = 0;

  // traffic shaping, written by the test sequence
  int send_gap_pct = 35;
  int recv_gap_pct = 35;
  int hold_request = 0;

  logic [7:0] frame_buf [$];

  function automatic void clear_frame_state();
    int i;
    byte_index = '0;
    type_high  = '0;
    keep_frame = 1'b1;
    ip_length  = '0;
    for (i = 0; i < WIN_DEPTH; i++) win[i] = '0;
    win_fill   = '0;
    http_seen  = 1'b0;
    emitted    = '0;
  endfunction

  // keyword starting at window slot idx, with at least one byte behind it
  function automatic bit keyword_at(int idx, logic [63:0] txt, int len);
    int k;
    if (int'(win_fill) < idx + len + 1) return 1'b0;
    for (k = 0; k < len; k++) begin
      if (win[idx + k] != txt[8 * (len - 1 - k) +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // settle one window position: look for a keyword, then emit if capturing
  function automatic void decide_position(int idx, int offset);
    if (idx >= WIN_DEPTH) return;
    if (!http_seen && (keyword_at(idx, TXT_GET, 3) || keyword_at(idx, TXT_POST, 4) ||
                       keyword_at(idx, TXT_HTTP, 8)))
      http_seen = 1'b1;
    if (http_seen && emitted < CAPTURE_LIMIT && step_count < WIN_DEPTH) begin
      step_bytes[step_count]   = win[idx];
      step_offsets[step_count] = offset[15:0];
      step_count++;
      emitted++;
    end
  endfunction

  function automatic void drop_oldest();
    int i;
    if (win_fill == 0) return;
    for (i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i + 1];
    win[WIN_DEPTH - 1] = '0;
    win_fill--;
  endfunction

  // advance the predictor by one frame byte and queue the captures it yields
  function automatic void filter_frame_byte(logic [7:0] b, logic eof);
    int   pos;
    int   off;
    int   base;
    int   i;
    bit   region_end;
    cap_t c;
    pos        = int'(byte_index);
    step_count = 0;
    region_end = 1'b0;
    if (pos == ETH_TYPE_HI) type_high = b;
    if (pos == ETH_TYPE_LO && !(type_high == ETHERTYPE_IPV4[15:8] && b == ETHERTYPE_IPV4[7:0]))
      keep_frame = 1'b0;
    if (keep_frame && pos >= IP_START) begin
      off = pos - IP_START;
      if (off == IP_LEN_HI_OFF) ip_length = {b, 8'h00};
      if (off == IP_LEN_LO_OFF) begin
        ip_length[7:0] = b;
        if (ip_length < MIN_REGION) keep_frame = 1'b0;
      end
      if (off == IP_PROTO_OFF && b != IP_PROTO_TCP) keep_frame = 1'b0;
      if (keep_frame) begin
        region_end = eof || (off >= IP_LEN_LO_OFF && off + 1 >= int'(ip_length));
        if (region_end && off < MIN_END_OFF) begin
          keep_frame = 1'b0;
          region_end = 1'b0;
        end else begin
          if (win_fill >= WIN_DEPTH) begin
            decide_position(0, off - WIN_DEPTH);
            drop_oldest();
          end
          win[win_fill] = b;
          win_fill++;
          if (region_end) begin
            // region over: settle every pending position with what exists
            base = off + 1 - int'(win_fill);
            for (i = 0; i < int'(win_fill); i++) decide_position(i, base + i);
            win_fill   = '0;
            keep_frame = 1'b0;
          end else if (off >= IP_PROTO_OFF && win_fill >= WIN_DEPTH) begin
            decide_position(0, off + 1 - WIN_DEPTH);
            drop_oldest();
          end
        end
      end
    end
    for (i = 0; i < step_count; i++) begin
      c.data   = step_bytes[i];
      c.offset = step_offsets[i];
      c.last   = region_end && (i == step_count - 1);
      captures_due.push_back(c);
    end
    if (byte_index < POS_MAX) byte_index++;
    if (eof) clear_frame_state();
  endfunction

  // -------------------------------------------------------------------------
  // predictor and checker share one edge process: input transfers are
  // predicted first, then the output transfer at the same edge is compared
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    cap_t want;
    if (!rst_n) begin
      clear_frame_state();
    end else begin
      if (in_tvalid && in_tready) filter_frame_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (captures_due.size() == 0) begin
          errors++;
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected capture: expected none, actual byte %h offset %h last %b",
                     $time, out_tdata[7:0], out_tdata[23:8], out_tlast);
        end else begin
          want = captures_due.pop_front();
          if (out_tdata[7:0] !== want.data || out_tdata[23:8] !== want.offset ||
              out_tlast !== want.last) begin
            errors++;
            if (errors < MAX_REPORTS)
              $display("%0t: capture mismatch: expected byte %h offset %h last %b, actual byte %h offset %h last %b",
                       $time, want.data, want.offset, want.last,
                       out_tdata[7:0], out_tdata[23:8], out_tlast);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here when requested
  always @(posedge clk) begin
    int hold_left;
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk) begin
    int stuck_cycles;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL http_start_capture_filter_core");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  // offer one byte with random gaps ahead of it; returns after its transfer
  task automatic send_byte(logic [7:0] b, logic eof);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // sender stops and waits until every predicted capture has come out
  task automatic wait_for_captures();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (captures_due.size() != 0) @(posedge clk);
  endtask

  // random frame bytes with the ethertype, ip total length and protocol set
  task automatic build_frame(logic [15:0] etype, logic [7:0] proto, int tot_len, int frame_len);
    int i;
    logic [15:0] len16;
    len16 = tot_len[15:0];
    frame_buf.delete();
    for (i = 0; i < frame_len; i++) frame_buf.push_back(8'($urandom_range(255)));
    if (frame_len > ETH_TYPE_HI) frame_buf[ETH_TYPE_HI] = etype[15:8];
    if (frame_len > ETH_TYPE_LO) frame_buf[ETH_TYPE_LO] = etype[7:0];
    if (frame_len > IP_START + IP_LEN_HI_OFF) frame_buf[IP_START + IP_LEN_HI_OFF] = len16[15:8];
    if (frame_len > IP_START + IP_LEN_LO_OFF) frame_buf[IP_START + IP_LEN_LO_OFF] = len16[7:0];
    if (frame_len > IP_START + IP_PROTO_OFF) frame_buf[IP_START + IP_PROTO_OFF] = proto;
  endtask

  // write a text into the ip region at the given offset, clipped to the frame
  task automatic plant(logic [63:0] txt, int len, int off);
    int k;
    for (k = 0; k < len; k++) begin
      if (IP_START + off + k < frame_buf.size())
        frame_buf[IP_START + off + k] = txt[8 * (len - 1 - k) +: 8];
    end
  endtask

  // a keyword or near miss somewhere in the region, clear of length and protocol
  task automatic plant_random_text(int region);
    logic [63:0] txt;
    int          len;
    int          start;
    case ($urandom_range(9))
      0, 1, 2: begin txt = TXT_GET;    len = 3; end
      3, 4:    begin txt = TXT_POST;   len = 4; end
      5, 6:    begin txt = TXT_HTTP;   len = 8; end
      7:       begin txt = TXT_POS;    len = 3; end
      8:       begin txt = TXT_HTTP10; len = 8; end
      default: begin txt = TXT_GE;     len = 2; end
    endcase
    start = $urandom_range(IP_LEN_LO_OFF + 1, region - 1);
    if (start < MIN_END_OFF && start + len > IP_PROTO_OFF) start = MIN_END_OFF;
    plant(txt, len, start);
  endtask

  // -------------------------------------------------------------------------
  // tests
  // -------------------------------------------------------------------------

  // each keyword opening the capture; region ended by length, by end of frame
  task automatic test_http_keywords();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 14, IP_START + 16);
    plant(TXT_GET, 3, 10);
    send_frame();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 16'hFFFF, IP_START + 15);
    plant(TXT_POST, 4, 10);
    frame_buf[IP_START + 14] = 8'hFF;
    send_frame();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 19, IP_START + 19);
    plant(TXT_HTTP, 8, 10);
    frame_buf[IP_START + 18] = 8'h00;
    send_frame();
    wait_for_captures();
  endtask

  // frames that must yield nothing, most of them despite carrying a keyword
  task automatic test_rejected_frames();
    build_frame(16'h0806, IP_PROTO_TCP, 20, IP_START + 16);
    plant(TXT_GET, 3, 10);
    send_frame();
    build_frame(ETHERTYPE_IPV4, 8'd17, 20, IP_START + 20);
    plant(TXT_GET, 3, 10);
    send_frame();
    // total length below the minimum region
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, MIN_REGION - 1, IP_START + 16);
    plant(TXT_GET, 3, 4);
    send_frame();
    // frame ends before the region is long enough
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 40, IP_START + MIN_END_OFF);
    send_frame();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 40, 5);
    send_frame();
    wait_for_captures();
  endtask

  // keyword with no byte behind it, near misses, keyword inside the ip header
  task automatic test_keyword_edges();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 13, IP_START + 13);
    plant(TXT_GET, 3, 10);
    send_frame();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 24, IP_START + 24);
    plant(TXT_POS, 3, 10);
    plant(TXT_HTTP10, 8, 14);
    send_frame();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 20, IP_START + 22);
    plant(TXT_GET, 3, 4);
    send_frame();
    wait_for_captures();
  endtask

  // receiver holds off for a long stretch while a capturing frame streams in
  task automatic test_output_hold();
    send_gap_pct = 0;
    hold_request = HOLD_CYCLES;
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 60, IP_START + 60);
    plant(TXT_GET, 3, 10);
    send_frame();
    build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, 30, IP_START + 30);
    plant(TXT_HTTP, 8, 12);
    send_frame();
    wait_for_captures();
    send_gap_pct = 35;
  endtask

  // mostly well-formed tcp frames with random content, plus broken frames and noise
  task automatic test_random_traffic();
    int          sent;
    int          kind;
    int          region;
    int          tot;
    int          trailing;
    logic [15:0] etype;
    logic [7:0]  proto;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      // a stretch in the middle runs with no idling on either side
      send_gap_pct = (sent >= 120 && sent < 220) ? 0 : 35;
      recv_gap_pct = send_gap_pct;
      kind = $urandom_range(99);
      if (kind < 70) begin
        region = $urandom_range(MIN_REGION, 40);
        if ($urandom_range(1)) begin
          tot      = region;
          trailing = $urandom_range(3);
        end else begin
          tot      = ($urandom_range(3) == 0) ? 16'hFFFF : region + $urandom_range(1, 200);
          trailing = 0;
        end
        build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, tot, IP_START + region + trailing);
        plant_random_text(region);
        if ($urandom_range(3) == 0) plant_random_text(region);
      end else if (kind < 80) begin
        etype = 16'($urandom_range(16'hFFFF));
        if (etype == ETHERTYPE_IPV4) etype[$urandom_range(15)] = ~etype[0];
        if (etype == ETHERTYPE_IPV4) etype = 16'h86DD;
        build_frame(etype, IP_PROTO_TCP, 30, IP_START + $urandom_range(0, 30));
        plant_random_text(20);
      end else if (kind < 88) begin
        proto = 8'($urandom_range(255));
        if (proto == IP_PROTO_TCP) proto = proto ^ (8'h01 << $urandom_range(7));
        region = $urandom_range(MIN_REGION, 30);
        build_frame(ETHERTYPE_IPV4, proto, region, IP_START + region);
        plant_random_text(region);
      end else if (kind < 94) begin
        if ($urandom_range(1))
          build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, $urandom_range(0, MIN_REGION - 1),
                      IP_START + $urandom_range(IP_LEN_LO_OFF + 1, 20));
        else
          build_frame(ETHERTYPE_IPV4, IP_PROTO_TCP, $urandom_range(MIN_REGION, 200),
                      $urandom_range(1, IP_START + MIN_END_OFF));
      end else begin
        build_frame(16'($urandom), 8'($urandom), $urandom_range(16'hFFFF),
                    $urandom_range(1, 30));
      end
      send_frame();
      sent += frame_buf.size();
      // now and then the sender pauses until the block has drained
      if ($urandom_range(7) == 0) wait_for_captures();
    end
    send_gap_pct = 35;
    recv_gap_pct = 35;
    wait_for_captures();
  endtask

  // -------------------------------------------------------------------------
  // sequence
  // -------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_http_keywords();
    test_rejected_frames();
    test_keyword_edges();
    test_output_hold();
    test_random_traffic();
    wait_for_captures();
    // let any stray capture show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && captures_due.size() == 0) begin
      $display("PASS http_start_capture_filter_core");
    end else begin
      $display("FAIL http_start_capture_filter_core");
    end
    $finish;
  end

endmodule
